@@ rtl/pair_sort_dedup_top_assert.svh @@
// Assertion macros shared by the pair sort and dedup RTL.
`ifndef PAIR_SORT_DEDUP_TOP_ASSERT_SVH
`define PAIR_SORT_DEDUP_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define PSD_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("pair_sort_dedup: invariant violated");

// A consequence that must hold in the same cycle as its cause.
`define PSD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pair_sort_dedup: same-cycle check failed");

// A consequence that must hold in the cycle after its cause.
`define PSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pair_sort_dedup: next-cycle check failed");

`endif

@@ rtl/psd_pkg.sv @@
// Shared constants and types of the pair sort and dedup block.
package psd_pkg;

    localparam int CAPACITY   = 64;
    localparam int INDEX_BITS = 20;
    localparam int TAG_BITS   = 16;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    // Sort key: fields in order of significance.
    typedef struct packed {
        logic [INDEX_BITS-1:0] a_start;
        logic [INDEX_BITS-1:0] a_end;
        logic [INDEX_BITS-1:0] b_start;
        logic [INDEX_BITS-1:0] b_end;
    } t_key;

    typedef struct packed {
        t_key                key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    // Row control: insert the broadcast pair, or shift everything toward cell 0.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

@@ rtl/psd_cell.sv @@
// One cell of the sorting row: holds a single pair and trades with its neighbors.
module psd_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psd_pkg::t_cell_ctrl i_ctrl,
    input  psd_pkg::t_entry     i_new,
    input  psd_pkg::t_slot      i_left,
    input  logic                i_left_gt,
    input  psd_pkg::t_slot      i_right,
    output psd_pkg::t_slot      o_slot,
    output logic                o_gt
);
    import psd_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;

    function automatic logic key_lt(input t_key x, input t_key y);
        logic [4*INDEX_BITS-1:0] vx;
        logic [4*INDEX_BITS-1:0] vy;
        vx = {x.a_start, x.a_end, x.b_start, x.b_end};
        vy = {y.a_start, y.a_end, y.b_start, y.b_end};
        return vx < vy;
    endfunction

    // The new pair belongs in front of this cell when the cell is empty or holds a
    // strictly larger key. An equal key stays ahead, which keeps arrival order.
    assign o_gt = !r_valid || key_lt(i_new.key, r_entry.key);

    // When the left neighbor also moves, this cell takes its slot, valid bit included,
    // so empty cells past the end of the filled run stay empty.
    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctrl.shift) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end else if (i_ctrl.load && o_gt) begin
            n_valid = i_left_gt ? i_left.valid : 1'b1;
            n_entry = i_left_gt ? i_left.entry : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_slot = '{valid: r_valid, entry: r_entry};

endmodule

@@ rtl/psd_row.sv @@
// Row of sorting cells; cell 0 holds the smallest pair.
module psd_row (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psd_pkg::t_cell_ctrl i_ctrl,
    input  psd_pkg::t_entry     i_new,
    output psd_pkg::t_slot      o_head
);
    import psd_pkg::*;

    t_slot w_slot [CAPACITY];
    logic  w_gt   [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_slot  w_left;
        logic   w_left_gt;
        t_slot  w_right;

        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_inner
            assign w_left    = w_slot[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_slot[g+1];
        end

        psd_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (i_ctrl),
            .i_new    (i_new),
            .i_left   (w_left),
            .i_left_gt(w_left_gt),
            .i_right  (w_right),
            .o_slot   (w_slot[g]),
            .o_gt     (w_gt[g])
        );
    end

    assign o_head = w_slot[0];

endmodule

@@ rtl/pair_sort_dedup_top.sv @@
// Top level of the pair sort and dedup block: intake, row control and result output.
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ------------------------------------------
//  input     start high while busy low    i_a_start .. i_b_end, i_pair_tag, i_set_done
//  result    o_result_valid for 1 cycle   o_out_a_start .. o_out_tag, o_out_final,
//                                         o_out_dropped_any
//
// While a set is loading, one pair is taken in every cycle: each pair is broadcast to
// the row of cells and, if there is room, is registered at its sorted place.
// After the closing pair, busy stays high while the row shifts one pair out of cell 0
// per cycle and until the row is empty, which flushes the last unique pair. Results
// trail the shift: each unique pair is held, then passes through the result register.
// Reset is synchronous and clears the cell valid bits, the count and the state at once.
// The receiver cannot stall; each result is a one-cycle transfer.
module pair_sort_dedup_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [psd_pkg::INDEX_BITS-1:0]  i_a_start,
    input  logic [psd_pkg::INDEX_BITS-1:0]  i_a_end,
    input  logic [psd_pkg::INDEX_BITS-1:0]  i_b_start,
    input  logic [psd_pkg::INDEX_BITS-1:0]  i_b_end,
    input  logic [psd_pkg::TAG_BITS-1:0]    i_pair_tag,
    input  logic                            i_set_done,
    output logic                            o_result_valid,
    output logic [psd_pkg::INDEX_BITS-1:0]  o_out_a_start,
    output logic [psd_pkg::INDEX_BITS-1:0]  o_out_a_end,
    output logic [psd_pkg::INDEX_BITS-1:0]  o_out_b_start,
    output logic [psd_pkg::INDEX_BITS-1:0]  o_out_b_end,
    output logic [psd_pkg::TAG_BITS-1:0]    o_out_tag,
    output logic                            o_out_final,
    output logic                            o_out_dropped_any
);
    import psd_pkg::*;

`include "pair_sort_dedup_top_assert.svh"

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(CAPACITY);

    logic                  r_state;
    logic                  n_state;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  r_overflow;
    logic                  n_overflow;

    // Last unique pair taken from the row, held until we know whether it is final.
    logic                  r_pend_valid;
    logic                  n_pend_valid;
    t_entry                r_pend;
    t_entry                n_pend;

    logic                  r_res_valid;
    logic                  n_res_valid;
    logic                  r_res_final;
    logic                  n_res_final;
    logic                  r_res_drop;
    logic                  n_res_drop;
    t_entry                r_res;
    t_entry                n_res;

    logic                  w_accept;
    t_cell_ctrl            w_ctrl;
    t_entry                w_new;
    t_slot                 w_head;

    assign busy     = (r_state == ST_EMIT);
    assign w_accept = start && !busy;

    assign w_new.key.a_start = i_a_start;
    assign w_new.key.a_end   = i_a_end;
    assign w_new.key.b_start = i_b_start;
    assign w_new.key.b_end   = i_b_end;
    assign w_new.tag         = i_pair_tag;

    // A pair is inserted only while there is room; otherwise it is dropped and flagged.
    assign w_ctrl.load  = w_accept && (r_count != COUNT_FULL);
    assign w_ctrl.shift = (r_state == ST_EMIT);

    psd_row u_row (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl),
        .i_new  (w_new),
        .o_head (w_head)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_overflow   = r_overflow;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_res_valid  = 1'b0;
        n_res_final  = 1'b0;
        n_res_drop   = r_overflow;
        n_res        = r_pend;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (r_count != COUNT_FULL) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_set_done) begin
                        n_state      = ST_EMIT;
                        n_pend_valid = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                if (w_head.valid) begin
                    // Equal tuples leave the row back to back, earliest arrival first,
                    // so a match against the held pair is a duplicate to skip.
                    if (!(r_pend_valid && (w_head.entry.key == r_pend.key))) begin
                        n_res_valid  = r_pend_valid;
                        n_pend       = w_head.entry;
                        n_pend_valid = 1'b1;
                    end
                end else begin
                    // Row is empty: the held pair is the last unique one of the set.
                    n_res_valid  = 1'b1;
                    n_res_final  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_count      = '0;
                    n_overflow   = 1'b0;
                    n_state      = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_overflow   <= n_overflow;
            r_pend_valid <= n_pend_valid;
            r_res_valid  <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend      <= n_pend;
        r_res       <= n_res;
        r_res_final <= n_res_final;
        r_res_drop  <= n_res_drop;
    end

    assign o_result_valid    = r_res_valid;
    assign o_out_a_start     = r_res.key.a_start;
    assign o_out_a_end       = r_res.key.a_end;
    assign o_out_b_start     = r_res.key.b_start;
    assign o_out_b_end       = r_res.key.b_end;
    assign o_out_tag         = r_res.tag;
    assign o_out_final       = r_res_final;
    assign o_out_dropped_any = r_res_drop;

    `PSD_ASSERT_ALWAYS(a_count_in_range, r_count <= COUNT_FULL)
    `PSD_ASSERT_SAME(a_overflow_only_when_full, r_overflow, r_count == COUNT_FULL)
    `PSD_ASSERT_SAME(a_result_from_emit, r_res_valid, $past(r_state) == ST_EMIT)
    `PSD_ASSERT_SAME(a_final_ends_set, r_res_valid && r_res_final, r_state == ST_LOAD)
    `PSD_ASSERT_NEXT(a_count_steps, w_accept && (r_count != COUNT_FULL),
        r_count == $past(r_count) + 1'b1)

endmodule

@@ dv/psd_tb_pkg.sv @@
// Expected-result tracker for the pair sort and dedup block: set model and result checks.
`timescale 1ns / 1ps

package psd_tb_pkg;

    import psd_pkg::*;

    typedef struct {
        t_entry entry;
        bit     is_last;
        bit     dropped;
    } t_sorted_pair;

    class pair_set_tracker;

        t_entry       loaded_q[$];
        bit           overflow_seen;
        t_sorted_pair sorted_due_q[$];
        int unsigned  pairs_noted;
        int unsigned  sets_closed;
        int unsigned  overflow_sets;
        int unsigned  results_checked;
        int unsigned  mismatch_count;

        // Store one accepted pair while there is room; on the closing pair, work out the whole emission.
        function void note_pair(t_entry pair, bit set_done);
            t_entry       ordered_q[$];
            t_sorted_pair due;
            int           j;
            pairs_noted++;
            if (loaded_q.size() < CAPACITY) begin
                loaded_q.push_back(pair);
            end else begin
                overflow_seen = 1'b1;
            end
            if (!set_done) begin
                return;
            end
            // Stable insertion by the whole tuple: equal keys keep arrival order.
            foreach (loaded_q[i]) begin
                j = ordered_q.size();
                while (j > 0 && ordered_q[j-1].key > loaded_q[i].key) begin
                    j--;
                end
                ordered_q.insert(j, loaded_q[i]);
            end
            foreach (ordered_q[i]) begin
                if (i > 0 && ordered_q[i].key == ordered_q[i-1].key) begin
                    continue;
                end
                due.entry   = ordered_q[i];
                due.is_last = 1'b0;
                due.dropped = overflow_seen;
                sorted_due_q.push_back(due);
            end
            sorted_due_q[sorted_due_q.size()-1].is_last = 1'b1;
            sets_closed++;
            if (overflow_seen) begin
                overflow_sets++;
            end
            loaded_q.delete();
            overflow_seen = 1'b0;
        endfunction

        // Compare one emitted result with the oldest outstanding one.
        function void check_emitted(t_entry got, bit got_last, bit got_dropped);
            t_sorted_pair want;
            if (sorted_due_q.size() == 0) begin
                $error("unexpected result: a_start %h a_end %h b_start %h b_end %h tag %h",
                       got.key.a_start, got.key.a_end, got.key.b_start, got.key.b_end,
                       got.tag);
                mismatch_count++;
                return;
            end
            want = sorted_due_q.pop_front();
            results_checked++;
            if (got.key.a_start !== want.entry.key.a_start) begin
                $error("out_a_start: expected %h, actual %h",
                       want.entry.key.a_start, got.key.a_start);
                mismatch_count++;
            end
            if (got.key.a_end !== want.entry.key.a_end) begin
                $error("out_a_end: expected %h, actual %h",
                       want.entry.key.a_end, got.key.a_end);
                mismatch_count++;
            end
            if (got.key.b_start !== want.entry.key.b_start) begin
                $error("out_b_start: expected %h, actual %h",
                       want.entry.key.b_start, got.key.b_start);
                mismatch_count++;
            end
            if (got.key.b_end !== want.entry.key.b_end) begin
                $error("out_b_end: expected %h, actual %h",
                       want.entry.key.b_end, got.key.b_end);
                mismatch_count++;
            end
            if (got.tag !== want.entry.tag) begin
                $error("out_tag: expected %h, actual %h", want.entry.tag, got.tag);
                mismatch_count++;
            end
            if (got_last !== want.is_last) begin
                $error("out_final: expected %b, actual %b", want.is_last, got_last);
                mismatch_count++;
            end
            if (got_dropped !== want.dropped) begin
                $error("dropped_any: expected %b, actual %b", want.dropped, got_dropped);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return sorted_due_q.size();
        endfunction

    endclass

endpackage

@@ dv/tb_top.sv @@
// Top-level testbench of the pair sort and dedup block: stimulus, monitors and verdict.
`timescale 1ns / 1ps

module tb_top;

    import psd_pkg::*;
    import psd_tb_pkg::*;

    localparam logic [INDEX_BITS-1:0] IDX_MAX     = {INDEX_BITS{1'b1}};
    localparam logic [INDEX_BITS-1:0] IDX_ODD     = 20'hAAAAA;
    localparam logic [INDEX_BITS-1:0] IDX_EVEN    = 20'h55555;
    localparam int                    RAND_PAIRS  = 143;
    localparam int                    MAX_GAP     = 18;
    localparam int unsigned           LIMIT_CYCLES = 200_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [INDEX_BITS-1:0] i_a_start;
    logic [INDEX_BITS-1:0] i_a_end;
    logic [INDEX_BITS-1:0] i_b_start;
    logic [INDEX_BITS-1:0] i_b_end;
    logic [TAG_BITS-1:0]   i_pair_tag;
    logic                  i_set_done;
    logic                  o_result_valid;
    logic [INDEX_BITS-1:0] o_out_a_start;
    logic [INDEX_BITS-1:0] o_out_a_end;
    logic [INDEX_BITS-1:0] o_out_b_start;
    logic [INDEX_BITS-1:0] o_out_b_end;
    logic [TAG_BITS-1:0]   o_out_tag;
    logic                  o_out_final;
    logic                  o_out_dropped_any;

    pair_set_tracker tracker;
    int unsigned     cycle_count = 0;

    // 8 ns clock: 4 ns high, 4 ns low.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    pair_sort_dedup_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_a_start         (i_a_start),
        .i_a_end           (i_a_end),
        .i_b_start         (i_b_start),
        .i_b_end           (i_b_end),
        .i_pair_tag        (i_pair_tag),
        .i_set_done        (i_set_done),
        .o_result_valid    (o_result_valid),
        .o_out_a_start     (o_out_a_start),
        .o_out_a_end       (o_out_a_end),
        .o_out_b_start     (o_out_b_start),
        .o_out_b_end       (o_out_b_end),
        .o_out_tag         (o_out_tag),
        .o_out_final       (o_out_final),
        .o_out_dropped_any (o_out_dropped_any)
    );

    // Both monitors sample at the rising edge, so they see the values that held
    // during the cycle that edge closes. An input transfer takes place where start
    // is high and busy low; a result is taken whenever the strobe is high, because
    // the block gives the receiver no way to stall it.
    always @(posedge i_clk) begin
        t_entry seen;
        if (i_rst_n && start && !busy) begin
            seen.key.a_start = i_a_start;
            seen.key.a_end   = i_a_end;
            seen.key.b_start = i_b_start;
            seen.key.b_end   = i_b_end;
            seen.tag         = i_pair_tag;
            tracker.note_pair(seen, i_set_done);
        end
        if (i_rst_n && o_result_valid) begin
            seen.key.a_start = o_out_a_start;
            seen.key.a_end   = o_out_a_end;
            seen.key.b_start = o_out_b_start;
            seen.key.b_end   = o_out_b_end;
            seen.tag         = o_out_tag;
            tracker.check_emitted(seen, o_out_final, o_out_dropped_any);
        end
    end

    // Watchdog. The limit lies far beyond the slowest correct run, in which every pair
    // waits behind the longest gap and emissions carry up to 64 results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic t_entry make_pair(logic [INDEX_BITS-1:0] a_s, logic [INDEX_BITS-1:0] a_e,
                                         logic [INDEX_BITS-1:0] b_s, logic [INDEX_BITS-1:0] b_e,
                                         logic [TAG_BITS-1:0] tag);
        t_entry pair;
        pair.key.a_start = a_s;
        pair.key.a_end   = a_e;
        pair.key.b_start = b_s;
        pair.key.b_end   = b_e;
        pair.tag         = tag;
        return pair;
    endfunction

    // Dense sets draw from three values only, so equal tuples and equal prefixes
    // come up all the time. Sparse sets mix small values, extremes and full range.
    function automatic logic [INDEX_BITS-1:0] pick_index(bit dense);
        if (dense) begin
            return INDEX_BITS'($urandom_range(0, 2));
        end
        case ($urandom_range(0, 2))
            0:       return INDEX_BITS'($urandom_range(0, 3));
            1:       return $urandom_range(0, 1) ? IDX_MAX : '0;
            default: return INDEX_BITS'($urandom());
        endcase
    endfunction

    function automatic t_entry random_pair(bit dense);
        return make_pair(pick_index(dense), pick_index(dense), pick_index(dense),
                         pick_index(dense), TAG_BITS'($urandom_range(0, 65535)));
    endfunction

    // Present one pair and hold it until the block takes it. Start is left high,
    // so back-to-back pairs go out without a bubble.
    task automatic send_pair(input t_entry pair, input bit done);
        start      <= 1'b1;
        i_a_start  <= pair.key.a_start;
        i_a_end    <= pair.key.a_end;
        i_b_start  <= pair.key.b_start;
        i_b_end    <= pair.key.b_end;
        i_pair_tag <= pair.tag;
        i_set_done <= done;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop sending until every outstanding result has come out. The first edge
    // lets the input monitor note the pair that was just taken.
    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int  set_no;
        int  set_len;
        int  sent;
        bit  dense;
        bit  gappy;
        tracker = new();

        // Every input is driven from time zero, with reset held low at first.
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_a_start  <= '0;
        i_a_end    <= '0;
        i_b_start  <= '0;
        i_b_end    <= '0;
        i_pair_tag <= '0;
        i_set_done <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets. A single all-zero pair and a single all-ones pair give
        // one-result emissions at both ends of every field.
        send_pair(make_pair('0, '0, '0, '0, 16'h0000), 1'b1);
        send_pair(make_pair(IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX, 16'hFFFF), 1'b1);
        hold_until_drained();

        // Each field in turn decides the order, a_start outranks everything after
        // it, and the duplicates of the first tuple must come out with its tag.
        send_pair(make_pair(20'd5, 20'd9, 20'd3, 20'd3, 16'h00A1), 1'b0);
        send_pair(make_pair(20'd5, 20'd9, 20'd3, 20'd2, 16'h00A2), 1'b0);
        send_pair(make_pair(20'd5, 20'd9, 20'd2, 20'd7, 16'h00A3), 1'b0);
        send_pair(make_pair(20'd5, 20'd8, 20'd9, 20'd9, 16'h00A4), 1'b0);
        send_pair(make_pair(20'd4, IDX_MAX, IDX_MAX, IDX_MAX, 16'h00A5), 1'b0);
        send_pair(make_pair(20'd5, 20'd9, 20'd3, 20'd3, 16'h00B1), 1'b0);
        idle_for(3);
        send_pair(make_pair(20'd5, 20'd9, 20'd3, 20'd3, 16'h00B2), 1'b0);
        send_pair(make_pair(IDX_MAX, '0, '0, '0, 16'h00C1), 1'b0);
        send_pair(make_pair(IDX_ODD, IDX_EVEN, IDX_ODD, IDX_EVEN, 16'h5555), 1'b0);
        send_pair(make_pair(IDX_EVEN, IDX_ODD, IDX_EVEN, IDX_ODD, 16'hAAAA), 1'b1);

        // A set of one tuple only, then a set closed by a copy of its first pair.
        send_pair(make_pair(20'd77, 20'd77, 20'd77, 20'd77, 16'h0001), 1'b0);
        send_pair(make_pair(20'd77, 20'd77, 20'd77, 20'd77, 16'h0002), 1'b0);
        send_pair(make_pair(20'd77, 20'd77, 20'd77, 20'd77, 16'h0003), 1'b1);
        send_pair(make_pair(20'd12, 20'd0, 20'd1, IDX_MAX, 16'h1234), 1'b0);
        send_pair(make_pair(20'd12, 20'd0, 20'd1, IDX_MAX, 16'h4321), 1'b1);
        hold_until_drained();

        // Random sets. Set 2 fills the store exactly; set 5 runs past it by a few
        // pairs, so the closing pair is itself one of the discarded ones. The rest
        // are short. About a third of the sets go out with no gaps at all, and
        // after about a third the sender waits for the whole emission.
        sent   = 0;
        set_no = 0;
        while (sent < RAND_PAIRS) begin
            if (set_no == 2) begin
                set_len = CAPACITY;
            end else if (set_no == 5) begin
                set_len = CAPACITY + $urandom_range(1, 6);
            end else begin
                set_len = $urandom_range(1, 10);
            end
            dense = ($urandom_range(0, 2) != 0);
            gappy = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < set_len; k++) begin
                send_pair(random_pair(dense), k == set_len - 1);
                if (gappy) begin
                    idle_for($urandom_range(0, MAX_GAP));
                end
            end
            sent += set_len;
            set_no++;
            if ($urandom_range(0, 2) == 0) begin
                hold_until_drained();
            end
        end

        // Drain, then give the block room to show any stray result.
        hold_until_drained();
        repeat (CAPACITY + 8) @(posedge i_clk);

        $display("Covered %0d pairs in %0d sets (%0d past capacity); %0d sorted results checked.",
                 tracker.pairs_noted, tracker.sets_closed, tracker.overflow_sets,
                 tracker.results_checked);
        $display("Mismatching fields or stray results: %0d.", tracker.mismatch_count);
        if (tracker.mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
